FILE: rtl/core/swrl_pkg.sv
// Package for the sliding-window rate limiter: field widths, deny causes
// and configuration register indexes. No dependencies.
`default_nettype none

package swrl_pkg;

   localparam int NOW_BITS      = 48;
   localparam int WAIT_BITS     = 16;
   localparam int CAUSE_BITS    = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef logic [CAUSE_BITS-1:0]   cause_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   // deny causes
   localparam cause_type CAUSE_NONE     = 2'd0;
   localparam cause_type CAUSE_INTERVAL = 2'd1;
   localparam cause_type CAUSE_FULL     = 2'd2;

   // configuration register indexes
   localparam csr_idx_type REG_LIMIT_ENABLE = 2'd0;
   localparam csr_idx_type REG_MAX_PER_WIN  = 2'd1;
   localparam csr_idx_type REG_MIN_INTERVAL = 2'd2;

   localparam logic [WAIT_BITS-1:0] WAIT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/core/swrl_if.sv
// Request and response channel interfaces of the rate limiter.
// Depends on swrl_pkg.
`default_nettype none

interface swrl_req_if
   import swrl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [NOW_BITS-1:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink   (input valid, input now_ms, output ready);
endinterface

interface swrl_rsp_if
   import swrl_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 granted;
   cause_type            deny_cause;
   logic [WAIT_BITS-1:0] wait_ms;

   modport source (output valid, output granted, output deny_cause, output wait_ms,
                   input ready);
   modport sink   (input valid, input granted, input deny_cause, input wait_ms,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/core/swrl_alu.sv
// Shared add/subtract unit of the rate limiter sequencer.
// Stand-alone; no package needed.
`default_nettype none

module swrl_alu #(
   parameter int WIDTH = 49
) (
   input  wire logic [WIDTH-1:0] opa,
   input  wire logic [WIDTH-1:0] opb,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] res,
   output logic                  borrow
);

   logic [WIDTH-1:0] opb_x;
   logic [WIDTH:0]   full;

   assign opb_x  = sub ? ~opb : opb;
   assign full   = {1'b0, opa} + {1'b0, opb_x} + (WIDTH+1)'(sub);
   assign res    = full[WIDTH-1:0];
   // opa < opb on a subtract
   assign borrow = sub & ~full[WIDTH];

endmodule

`default_nettype wire

FILE: rtl/core/sliding_window_rate_limiter.sv
// Top level of the sliding-window rate limiter: grant-time FIFO in a memory,
// small sequencer driving one shared add/subtract unit. Uses swrl_pkg,
// swrl_req_if / swrl_rsp_if and swrl_alu.
//
//   channel  dir  handshake           payload
//   req      in   req.valid/ready     now_ms[47:0]
//   rsp      out  rsp.valid/ready     granted, deny_cause[1:0], wait_ms[15:0]
//   csr      in   csr_wr_en           csr_index[1:0], csr_wr_data[15:0]
//
// Steps: after accept an item runs the window start, the expiry pass
// (skipped while now_ms is below one window; pops each expired grant), the
// interval checks, the count check and on a window-full deny the wait step,
// then the result load; the pop rate is set by the single registered read
// port of the grant-time memory. With limit_enable low an item goes straight
// to the result load; the next accept is in the cycle after it at the earliest.
// Reset (synchronous, active high) empties the FIFO and loads register defaults;
// no clearing pass is needed since only entries inside the fill count are read.
// A result waiting in the output register does not stop the next accept;
// the result step holds only while that register is full and rsp.ready low.
`default_nettype none

module sliding_window_rate_limiter
   import swrl_pkg::*;
#(
   parameter int FIFO_DEPTH = 64,
   parameter int WINDOW_MS  = 60000,
   parameter int TIME_BITS  = 48
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   swrl_req_if.sink                      req,
   swrl_rsp_if.source                    rsp,
   input  wire logic                     csr_wr_en,
   input  wire csr_idx_type              csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wr_data
);

   localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_BITS = CNT_BITS + 1;
   localparam int CMP_BITS = (CNT_BITS > 7) ? CNT_BITS : 7;
   localparam int UW       = TIME_BITS + 1;   // unit width, one sign bit

   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FIFO_DEPTH - 1);
   localparam logic [SUM_BITS-1:0] DEPTH_S  = SUM_BITS'(FIFO_DEPTH);
   localparam logic [10:0]         DEPTH_L  = 11'(FIFO_DEPTH);
   localparam logic [UW-1:0]       WIN_U    = UW'(WINDOW_MS);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;   // window start = now - window
   localparam logic [3:0] S_POP    = 4'd2;   // drop expired heads
   localparam logic [3:0] S_INTV1  = 4'd3;   // now - last grant
   localparam logic [3:0] S_INTV2  = 4'd4;   // min interval - elapsed
   localparam logic [3:0] S_BACK1  = 4'd5;   // time went backwards: last - now
   localparam logic [3:0] S_BACK2  = 4'd6;   // min interval + backward gap
   localparam logic [3:0] S_FULL   = 4'd7;   // count check, oldest - now
   localparam logic [3:0] S_WFULL  = 4'd8;   // window-full wait
   localparam logic [3:0] S_RESULT = 4'd9;

   function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [UW-1:0] v);
      logic [63:0] v_x;
      v_x = 64'(v);
      sat_wait = (v_x[63:WAIT_BITS] != '0) ? WAIT_MAX : v_x[WAIT_BITS-1:0];
   endfunction

   logic [3:0]           state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [UW-1:0]        acc_ff, acc_in;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic                 en_ff, en_in;
   logic [6:0]           max_ff, max_in;
   logic [15:0]          min_ff, min_in;
   cause_type            cause_ff, cause_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   cause_type            rsp_cause_ff, rsp_cause_in;
   logic [WAIT_BITS-1:0] rsp_wait_ff, rsp_wait_in;

   logic [TIME_BITS-1:0] mem [FIFO_DEPTH];
   logic [TIME_BITS-1:0] rd_ff;   // mem[head], registered read
   logic                 mem_we;
   logic [PTR_BITS-1:0]  tail;
   logic [SUM_BITS-1:0]  tail_sum;

   logic [UW-1:0]        opa, opb, alu_res;
   logic                 alu_sub, alu_borrow;

   logic [63:0]          req_now_wide;
   logic [TIME_BITS-1:0] req_now;
   logic                 req_fire;
   logic                 out_free;
   logic                 window_full;
   logic [6:0]           max_wr;

   // time reduced to TIME_BITS
   assign req_now_wide = 64'(req.now_ms);
   assign req_now      = req_now_wide[TIME_BITS-1:0];

   assign req.ready   = (state_ff == S_IDLE);
   assign req_fire    = req.valid & req.ready;
   assign out_free    = ~rsp_valid_ff | rsp.ready;
   assign window_full = CMP_BITS'(count_ff) >= CMP_BITS'(max_ff);

   // tail = (head + count) mod depth, sum stays below twice the depth
   always_comb begin
      tail_sum = SUM_BITS'(head_ff) + SUM_BITS'(count_ff);
      if (tail_sum >= DEPTH_S) begin
         tail_sum = tail_sum - DEPTH_S;
      end
      tail = tail_sum[PTR_BITS-1:0];
   end

   // clamp of a max_per_window write to 1..depth
   always_comb begin
      max_wr = csr_wr_data[6:0];
      if (max_wr == 7'd0) begin
         max_wr = 7'd1;
      end
      if ({4'b0, max_wr} > DEPTH_L) begin
         max_wr = DEPTH_L[6:0];
      end
   end

   // operand select for the shared unit
   always_comb begin
      opa     = '0;
      opb     = '0;
      alu_sub = 1'b1;
      case (state_ff)
         S_START: begin
            opa = {1'b0, now_ff};
            opb = WIN_U;
         end
         S_POP: begin
            opa = {1'b0, rd_ff};
            opb = {1'b0, start_ff};
         end
         S_INTV1: begin
            opa = {1'b0, now_ff};
            opb = {1'b0, last_ff};
         end
         S_INTV2: begin
            opa = UW'(min_ff);
            opb = acc_ff;
         end
         S_BACK1: begin
            opa = {1'b0, last_ff};
            opb = {1'b0, now_ff};
         end
         S_BACK2: begin
            opa     = UW'(min_ff);
            opb     = UW'(sat_wait(acc_ff));
            alu_sub = 1'b0;
         end
         S_FULL: begin
            opa = {1'b0, rd_ff};
            opb = {1'b0, now_ff};
         end
         S_WFULL: begin
            // negative gap: oldest is in the past, keep signed; else saturate
            opa     = acc_ff[UW-1] ? acc_ff : UW'(sat_wait(acc_ff));
            opb     = WIN_U;
            alu_sub = 1'b0;
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   swrl_alu #(
      .WIDTH (UW)
   ) u_alu (
      .opa    (opa),
      .opb    (opb),
      .sub    (alu_sub),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      start_in       = start_ff;
      acc_in         = acc_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      last_in        = last_ff;
      en_in          = en_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      cause_in       = cause_ff;
      wait_in        = wait_ff;
      mem_we         = 1'b0;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_cause_in   = rsp_cause_ff;
      rsp_wait_in    = rsp_wait_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in   = req_now;
               cause_in = CAUSE_NONE;
               wait_in  = '0;
               state_in = en_ff ? S_START : S_RESULT;
            end
         end
         S_START: begin
            start_in = alu_res[TIME_BITS-1:0];
            // before the first full window nothing expires
            state_in = alu_borrow ? S_INTV1 : S_POP;
         end
         S_POP: begin
            if (count_ff != '0 && alu_borrow) begin
               head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               state_in = S_INTV1;
            end
         end
         S_INTV1: begin
            acc_in = alu_res;
            if (last_ff == '0) begin
               state_in = S_FULL;           // no grant yet
            end else if (alu_borrow) begin
               state_in = S_BACK1;
            end else begin
               state_in = S_INTV2;
            end
         end
         S_INTV2: begin
            if (!alu_borrow && alu_res != '0) begin
               cause_in = CAUSE_INTERVAL;
               wait_in  = alu_res[WAIT_BITS-1:0];
               state_in = S_RESULT;
            end else begin
               state_in = S_FULL;
            end
         end
         S_BACK1: begin
            acc_in   = alu_res;
            state_in = S_BACK2;
         end
         S_BACK2: begin
            cause_in = CAUSE_INTERVAL;
            wait_in  = sat_wait(alu_res);
            state_in = S_RESULT;
         end
         S_FULL: begin
            if (window_full) begin
               acc_in   = alu_res;
               cause_in = CAUSE_FULL;
               state_in = S_WFULL;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
               last_in  = now_ff;
               state_in = S_RESULT;
            end
         end
         S_WFULL: begin
            if (acc_ff[UW-1]) begin
               // already expired by the time of the retry: no wait
               wait_in = (alu_res[UW-1] || alu_res == '0) ? '0 : alu_res[WAIT_BITS-1:0];
            end else begin
               wait_in = sat_wait(alu_res);
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = (cause_ff == CAUSE_NONE);
               rsp_cause_in   = cause_ff;
               rsp_wait_in    = wait_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes, each also clears the history
      if (csr_wr_en) begin
         case (csr_index)
            REG_LIMIT_ENABLE: begin
               en_in    = csr_wr_data[0];
               head_in  = '0;
               count_in = '0;
               last_in  = '0;
            end
            REG_MAX_PER_WIN: begin
               max_in   = max_wr;
               head_in  = '0;
               count_in = '0;
               last_in  = '0;
            end
            REG_MIN_INTERVAL: begin
               min_in   = csr_wr_data[15:0];
               head_in  = '0;
               count_in = '0;
               last_in  = '0;
            end
            default: begin
               en_in = en_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= '0;
         en_ff        <= 1'b1;
         max_ff       <= 7'd60;
         min_ff       <= 16'd300;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         en_ff        <= en_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      start_ff       <= start_in;
      acc_ff         <= acc_in;
      cause_ff       <= cause_in;
      wait_ff        <= wait_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_cause_ff   <= rsp_cause_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

   // grant-time memory: one write, one registered read following the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail] <= now_ff;
      end
      rd_ff <= mem[head_in];
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.granted    = rsp_granted_ff;
   assign rsp.deny_cause = rsp_cause_ff;
   assign rsp.wait_ms    = rsp_wait_ff;

endmodule

`default_nettype wire

FILE: rtl/core/swrl_checker.sv
// Port-level checks for the rate limiter, bound to the top level.
// Depends on swrl_pkg and sliding_window_rate_limiter.
`default_nettype none

module swrl_checker
   import swrl_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_granted,
   input wire cause_type            rsp_deny_cause,
   input wire logic [WAIT_BITS-1:0] rsp_wait_ms
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) &&
      $stable(rsp_deny_cause) && $stable(rsp_wait_ms))
      else $error("rsp item changed while stalled");

   // grant flag and cause agree, cause is a known code
   a_grant_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_granted == (rsp_deny_cause == CAUSE_NONE)) &&
      (rsp_deny_cause == CAUSE_NONE || rsp_deny_cause == CAUSE_INTERVAL ||
       rsp_deny_cause == CAUSE_FULL))
      else $error("granted and deny_cause disagree");

   // grants carry no wait
   a_grant_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_wait_ms == '0)
      else $error("granted item with nonzero wait");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accept");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_granted    (rsp.granted),
   .rsp_deny_cause (rsp.deny_cause),
   .rsp_wait_ms    (rsp.wait_ms)
);

`default_nettype wire

FILE: sim/grant_checker.sv
`timescale 1ns / 100ps
// Checker for the sliding-window rate limiter: watches the request, response
// and register-write ports, predicts every ruling and compares it.
// Depends on swrl_pkg and the swrl_req_if / swrl_rsp_if interfaces.

module grant_checker
   import swrl_pkg::*;
#(
   parameter int LOG_DEPTH = 64,
   parameter int WINDOW_MS = 60000
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   swrl_req_if                           req,
   swrl_rsp_if                           rsp,
   input  wire logic                     csr_wr_en,
   input  wire csr_idx_type              csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wr_data,
   output int                            mismatches,
   output int                            outstanding
);

   typedef logic [NOW_BITS-1:0] stamp_t;

   typedef struct packed {
      logic                 granted;
      cause_type            deny_cause;
      logic [WAIT_BITS-1:0] wait_ms;
   } ruling_t;

   // grant history
   stamp_t      grant_log [LOG_DEPTH];
   int unsigned log_head;
   int unsigned log_fill;
   stamp_t      last_grant;

   // register copies
   logic        enforce;
   int unsigned max_grants;
   logic [15:0] min_gap;

   ruling_t rulings_due [$];

   function automatic logic [63:0] cap_wait(input logic [63:0] v);
      return (v > 64'(WAIT_MAX)) ? 64'(WAIT_MAX) : v;
   endfunction

   function automatic void forget_grants();
      log_head   = 0;
      log_fill   = 0;
      last_grant = '0;
   endfunction

   function automatic void apply_setting(input csr_idx_type idx,
                                         input logic [CSR_DATA_BITS-1:0] data);
      int unsigned m;
      case (idx)
         REG_LIMIT_ENABLE: begin
            enforce = data[0];
            forget_grants();
         end
         REG_MAX_PER_WIN: begin
            m = 32'(data[6:0]);
            if (m < 1) m = 1;
            if (m > LOG_DEPTH) m = LOG_DEPTH;
            max_grants = m;
            forget_grants();
         end
         REG_MIN_INTERVAL: begin
            min_gap = data[15:0];
            forget_grants();
         end
         default: ;  // unused index: no effect at all
      endcase
   endfunction

   function automatic ruling_t rule_on(input stamp_t now);
      ruling_t     r;
      logic [63:0] delay;
      stamp_t      front;
      int unsigned tail;
      r.deny_cause = CAUSE_NONE;
      delay        = '0;
      if (enforce) begin
         // retire grants that fell out of the window
         if (now >= stamp_t'(WINDOW_MS))
            while (log_fill > 0 && grant_log[log_head] < now - stamp_t'(WINDOW_MS)) begin
               log_head = (log_head + 1) % LOG_DEPTH;
               log_fill--;
            end
         if (last_grant != 0 && now < last_grant) begin
            r.deny_cause = CAUSE_INTERVAL;
            delay = cap_wait(64'(min_gap) + cap_wait(64'(last_grant - now)));
         end else if (last_grant != 0 && 64'(now - last_grant) < 64'(min_gap)) begin
            r.deny_cause = CAUSE_INTERVAL;
            delay = 64'(min_gap) - 64'(now - last_grant);
         end else if (log_fill >= max_grants) begin
            front        = grant_log[log_head];
            r.deny_cause = CAUSE_FULL;
            if (front >= now)
               delay = cap_wait(cap_wait(64'(front - now)) + 64'(WINDOW_MS));
            else if (64'(now - front) < 64'(WINDOW_MS))
               delay = 64'(WINDOW_MS) - 64'(now - front);
            else
               delay = '0;
         end else begin
            tail            = (log_head + log_fill) % LOG_DEPTH;
            grant_log[tail] = now;
            log_fill++;
            last_grant      = now;
         end
      end
      r.granted = (r.deny_cause == CAUSE_NONE);
      r.wait_ms = WAIT_BITS'(cap_wait(delay));
      return r;
   endfunction

   task automatic flag(input string what);
      if (mismatches < 10) $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      ruling_t due;
      if (reset) begin
         forget_grants();
         enforce    = 1'b1;
         max_grants = 60;
         min_gap    = 16'd300;
         rulings_due.delete();
         mismatches  = 0;
         outstanding <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (rulings_due.size() == 0) begin
               flag($sformatf("unexpected result granted=%0d cause=%0d wait=%0d",
                              rsp.granted, rsp.deny_cause, rsp.wait_ms));
            end else begin
               due = rulings_due[0];
               rulings_due.delete(0);
               if (rsp.granted !== due.granted || rsp.deny_cause !== due.deny_cause ||
                   rsp.wait_ms !== due.wait_ms)
                  flag($sformatf({"result mismatch: expected granted=%0d cause=%0d ",
                                  "wait=%0d, got granted=%0d cause=%0d wait=%0d"},
                                 due.granted, due.deny_cause, due.wait_ms,
                                 rsp.granted, rsp.deny_cause, rsp.wait_ms));
            end
         end
         if (req.valid && req.ready) rulings_due.push_back(rule_on(req.now_ms));
         if (csr_wr_en) apply_setting(csr_index, csr_wr_data);
         outstanding <= rulings_due.size();
      end
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the rate limiter testbench: clock, reset, request stimulus, response
// stalls and register writes. Needs swrl_pkg, the channel interfaces,
// sliding_window_rate_limiter and grant_checker.

module testbench;
   import swrl_pkg::*;

   localparam int LOG_DEPTH = 64;
   localparam int WINDOW_MS = 60000;
   localparam logic [NOW_BITS-1:0] LATEST = '1;
   // index 3 is not a register; a write there must leave everything alone
   localparam csr_idx_type REG_SPARE = 2'd3;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 86;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   csr_idx_type              csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wr_data;

   int mismatches;
   int outstanding;

   // idling knobs, changed per phase
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int stall_left   = 0;

   // pacing of request times, follows the last written limits
   int unsigned pace_max = 60;
   int unsigned pace_gap = 300;

   swrl_req_if req_ch ();
   swrl_rsp_if rsp_ch ();

   sliding_window_rate_limiter #(
      .FIFO_DEPTH (LOG_DEPTH),
      .WINDOW_MS  (WINDOW_MS),
      .TIME_BITS  (NOW_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   grant_checker #(
      .LOG_DEPTH (LOG_DEPTH),
      .WINDOW_MS (WINDOW_MS)
   ) judge (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Idle stretch length: mostly a few cycles, now and then a long one.
   function automatic int idle_span();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(3, 1);
      if (r < 95) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Response side backpressure. A stall runs for a whole idle span so the
   // result register sits full across several sequencer steps.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left   <= idle_span() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offer one request item and return at the edge that takes it. Valid stays
   // high afterwards so back-to-back items need no extra cycle.
   task automatic send_request(input logic [NOW_BITS-1:0] stamp);
      int gap;
      gap = ($urandom_range(99) < send_gap_pct) ? idle_span() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.now_ms <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Stop offering and wait until every ruling is back, plus a short pause
   // so the sequencer is surely idle before any register write.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the batch.
   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Every write also wipes the grant history, so the order does not matter.
   task automatic configure(input logic [15:0] en_word, input logic [15:0] max_word,
                            input logic [15:0] gap_word);
      drain();
      write_reg(REG_LIMIT_ENABLE, en_word);
      write_reg(REG_MAX_PER_WIN, max_word);
      write_reg(REG_MIN_INTERVAL, gap_word);
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, 16'($urandom));
      csr_wr_en <= 1'b0;
      pace_max = 32'(max_word[6:0]);
      if (pace_max == 0) pace_max = 1;
      if (pace_max > LOG_DEPTH) pace_max = LOG_DEPTH;
      pace_gap = 32'(gap_word);
   endtask

   task automatic pick_config(input int phase);
      logic [15:0] en_word;
      logic [15:0] max_word;
      logic [15:0] gap_word;
      case (phase)
         0: configure(16'd1, 16'd64, 16'd0);       // deepest window, no spacing
         1: configure(16'd1, 16'd1, 16'hFFFF);     // single grant, longest spacing
         2: configure(16'hFFFF, 16'hFF80, 16'd1);  // max field of zero acts as one
         3: configure(16'd1, 16'h007F, 16'd300);   // max above depth saturates
         4: configure(16'hFFFE, 16'd5, 16'd100);   // enable bit low: all granted
         5: configure(16'd1, 16'd65, 16'd50);
         default: begin
            en_word  = ($urandom_range(7) == 0) ? (16'($urandom) & 16'hFFFE)
                                                : (16'($urandom) | 16'd1);
            max_word = ($urandom_range(3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(127));
            case ($urandom_range(3))
               0:       gap_word = 16'd0;
               1:       gap_word = 16'($urandom_range(500));
               2:       gap_word = 16'($urandom_range(5000));
               default: gap_word = 16'($urandom);
            endcase
            configure(en_word, max_word, gap_word);
         end
      endcase
   endtask

   // Mostly a forward-moving clock paced around the limits so that interval
   // and window-full denials both show up; a few items jump far ahead (mass
   // expiry) or step back in time.
   task automatic random_phase();
      logic [63:0] tick;
      int unsigned span;
      logic [63:0] back;
      logic [63:0] sent;
      int          pick;
      if ($urandom_range(3) == 0) begin
         send_gap_pct = 0;
         stall_pct    = 0;
      end else begin
         send_gap_pct = $urandom_range(60, 10);
         stall_pct    = $urandom_range(60, 10);
      end
      case ($urandom_range(3))
         0:       tick = '0;
         1:       tick = 64'($urandom_range(59999));
         2:       tick = 64'(LATEST) - 64'($urandom_range(2000000));
         default: tick = {$urandom, $urandom} & 64'(LATEST);
      endcase
      span = 2 * pace_gap + 120000 / pace_max;
      repeat (ITEMS_PER_PHASE) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            back = 64'($urandom_range(70000, 1));
            sent = (tick > back) ? tick - back : '0;
         end else begin
            if (pick < 20)
               ;  // same time again
            else if (pick < 25)
               tick += 64'($urandom_range(300000, 60000));
            else if (pick < 27)
               tick += 64'($urandom) * 1000;
            else
               tick += 64'($urandom_range(span));
            if (tick > 64'(LATEST)) tick = 64'(LATEST);
            sent = tick;
         end
         send_request(sent[NOW_BITS-1:0]);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.now_ms <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= REG_LIMIT_ENABLE;
      csr_wr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register defaults after reset: enforcing, 60 per window, 300 ms apart.
      send_request('0);                 // grant at time zero keeps last time at zero
      send_request('0);                 // so the spacing check is skipped here
      send_request(48'd100);
      send_request(48'd50);             // time going backwards
      send_request(48'd200);            // too soon after the last grant
      send_request(48'd400);
      send_request(48'd60500);          // first time past the window: expiry
      send_request(LATEST);             // everything expires
      send_request(48'd5);              // huge backward gap: wait saturates
      send_request(LATEST);             // same time as last grant

      // One grant per window, no spacing.
      configure(16'd1, 16'd0, 16'd0);
      send_request(48'd1000);
      send_request(48'd1000);           // full, oldest entry at the same time
      send_request(48'd30000);          // full, partial wait
      send_request(48'd61000);          // oldest exactly one window back: zero wait
      send_request(48'd61001);          // now it expires

      // Write to the unused index: the history must survive it.
      drain();
      write_reg(REG_SPARE, 16'hFFFF);
      csr_wr_en <= 1'b0;
      send_request(48'd61001);

      // Enable bit low with all other data bits high: everything granted.
      configure(16'hFFFE, 16'd60, 16'd300);
      send_request('0);
      send_request(LATEST);
      send_request(48'd7);

      for (int phase = 0; phase < PHASES; phase++) begin
         pick_config(phase);
         random_phase();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #(10_000_000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
